[sv/cube_sphere_face_vertex_gen_macros.svh]
// Assertion macros used by the checker file.
`ifndef CUBE_SPHERE_FACE_VERTEX_GEN_MACROS_SVH
`define CUBE_SPHERE_FACE_VERTEX_GEN_MACROS_SVH

// Checked property, idle while reset is asserted.
`define CSFV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds while reset is asserted.
`define CSFV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/csfv_pkg.sv]
// Package: constants, types and table functions of the cube-sphere vertex generator.
package csfv_pkg;

    localparam int MAX_LEVEL_DEF = 8;
    localparam int FRAC          = 30;
    localparam int TW            = 31;     // trig magnitude, Q30 up to 1.0
    localparam int VW            = 31;     // cross product component
    localparam int SQW           = 64;     // sum of squares
    localparam int NW            = 32;     // norm
    localparam int LW            = 4;      // level register
    localparam int RW            = 16;     // radius register
    localparam int QW            = 16;     // quotient bits (q <= radius)
    localparam int DVW           = 48;     // dividend width
    localparam int IW            = 9;      // grid index width
    localparam int OW            = 16;     // output coordinate width
    localparam int CFG_IW        = 1;
    localparam int CFG_DW        = 16;

    localparam logic [LW-1:0] LEVEL_RESET  = 4'd5;
    localparam logic [RW-1:0] RADIUS_RESET = 16'd16384;

    localparam logic [63:0] ONE_Q        = 64'd1 << FRAC;
    localparam logic [63:0] QUARTER_PI_Q = 64'd843314857;

    typedef enum logic [CFG_IW-1:0] {
        REG_LEVEL  = 1'b0,
        REG_RADIUS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic err;
        logic neg_y;
        logic neg_z;
    } side_t;

    function automatic logic [63:0] angle_q(input int unsigned m, input int unsigned maxlev);
        angle_q = (QUARTER_PI_Q * 64'(m)) >> maxlev;
    endfunction

    // sin magnitude (Q30) of angle (pi/4)*m/2^maxlev
    function automatic logic [63:0] grid_sin(input int unsigned m, input int unsigned maxlev);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = angle_q(m, maxlev);
        x2 = (x * x) >> FRAC;
        t  = ONE_Q - x2 / 72;
        t  = ONE_Q - ((x2 * t) >> FRAC) / 42;
        t  = ONE_Q - ((x2 * t) >> FRAC) / 20;
        t  = ONE_Q - ((x2 * t) >> FRAC) / 6;
        grid_sin = (x * t) >> FRAC;
    endfunction

    function automatic logic [63:0] grid_cos(input int unsigned m, input int unsigned maxlev);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = angle_q(m, maxlev);
        x2 = (x * x) >> FRAC;
        t  = ONE_Q - x2 / 56;
        t  = ONE_Q - ((x2 * t) >> FRAC) / 30;
        t  = ONE_Q - ((x2 * t) >> FRAC) / 12;
        t  = ONE_Q - ((x2 * t) >> FRAC) / 2;
        grid_cos = t;
    endfunction

endpackage

[sv/csfv_if.sv]
// Stream interfaces: grid index items in, vertex items out.
interface csfv_grid_if;
    logic                      valid;
    logic                      ready;
    logic [csfv_pkg::IW-1:0]   row_index;
    logic [csfv_pkg::IW-1:0]   col_index;

    modport source (output valid, output row_index, output col_index, input ready);
    modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

interface csfv_vertex_if;
    logic                             valid;
    logic                             ready;
    logic signed [csfv_pkg::OW-1:0]   vert_x;
    logic signed [csfv_pkg::OW-1:0]   vert_y;
    logic signed [csfv_pkg::OW-1:0]   vert_z;
    logic                             index_error;

    modport source (output valid, output vert_x, output vert_y, output vert_z,
                    output index_error, input ready);
    modport sink   (input valid, input vert_x, input vert_y, input vert_z,
                    input index_error, output ready);
endinterface

[sv/cube_sphere_face_vertex_gen.sv]
// Top level of the cube-sphere +X face vertex generator.
//  channel  | dir | payload
//  grid     | in  | row_index[8:0], col_index[8:0]
//  vertex   | out | vert_x, vert_y, vert_z (Q1.15), index_error
//  cfg      | in  | cfg_we, cfg_index, cfg_data (level, sphere_radius)
// One item per cycle while the output is not stalled; pipeline stages: table lookup 1, vector math 3,
// square root 32 (one bit per stage), dividend 1, divide 16 (one bit per stage), output 1.
// Reset clears the valid bits and loads level 5, radius 16384; no clearing pass.
// A stall at the output freezes the whole pipeline; grid.ready drops with it.
module cube_sphere_face_vertex_gen #(
    parameter int MAX_LEVEL = csfv_pkg::MAX_LEVEL_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [csfv_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [csfv_pkg::CFG_DW-1:0]    cfg_data,
    csfv_grid_if.sink                      grid,
    csfv_vertex_if.source                  vertex
);
    logic [csfv_pkg::LW-1:0] level_reg;
    logic [csfv_pkg::RW-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= csfv_pkg::LEVEL_RESET;
            radius_reg <= csfv_pkg::RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (csfv_pkg::reg_idx_t'(cfg_index))
                csfv_pkg::REG_LEVEL:  level_reg  <= cfg_data[csfv_pkg::LW-1:0];
                csfv_pkg::REG_RADIUS: radius_reg <= cfg_data[csfv_pkg::RW-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid;

    assign en          = !out_valid || vertex.ready;
    assign grid.ready  = en;
    assign vertex.valid = out_valid;

    logic                     t_valid;
    csfv_pkg::side_t          t_side;
    logic [csfv_pkg::TW-1:0]  s1;
    logic [csfv_pkg::TW-1:0]  c1;
    logic [csfv_pkg::TW-1:0]  s2;
    logic [csfv_pkg::TW-1:0]  c2;

    csfv_trig #(.MAX_LEVEL(MAX_LEVEL)) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (grid.valid),
        .row_index (grid.row_index),
        .col_index (grid.col_index),
        .level     (level_reg),
        .out_valid (t_valid),
        .out_side  (t_side),
        .s1        (s1),
        .c1        (c1),
        .s2        (s2),
        .c2        (c2)
    );

    logic                      v_valid;
    csfv_pkg::side_t           v_side;
    logic [csfv_pkg::VW-1:0]   vx;
    logic [csfv_pkg::VW-1:0]   vy;
    logic [csfv_pkg::VW-1:0]   vz;
    logic [csfv_pkg::SQW-1:0]  sumsq;

    csfv_vec u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t_valid),
        .in_side   (t_side),
        .s1        (s1),
        .c1        (c1),
        .s2        (s2),
        .c2        (c2),
        .out_valid (v_valid),
        .out_side  (v_side),
        .vx        (vx),
        .vy        (vy),
        .vz        (vz),
        .sumsq     (sumsq)
    );

    logic                      r_valid;
    csfv_pkg::side_t           r_side;
    logic [csfv_pkg::VW-1:0]   r_vx;
    logic [csfv_pkg::VW-1:0]   r_vy;
    logic [csfv_pkg::VW-1:0]   r_vz;
    logic [csfv_pkg::NW-1:0]   norm;

    csfv_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_valid),
        .in_side   (v_side),
        .in_vx     (vx),
        .in_vy     (vy),
        .in_vz     (vz),
        .sumsq     (sumsq),
        .out_valid (r_valid),
        .out_side  (r_side),
        .out_vx    (r_vx),
        .out_vy    (r_vy),
        .out_vz    (r_vz),
        .norm      (norm)
    );

    csfv_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (r_valid),
        .in_side     (r_side),
        .vx          (r_vx),
        .vy          (r_vy),
        .vz          (r_vz),
        .norm        (norm),
        .radius      (radius_reg),
        .out_valid   (out_valid),
        .vert_x      (vertex.vert_x),
        .vert_y      (vertex.vert_y),
        .vert_z      (vertex.vert_z),
        .index_error (vertex.index_error)
    );
endmodule

[sv/csfv_trig.sv]
// Index check, finest-grid mapping and sine/cosine table lookup (one stage).
module csfv_trig #(
    parameter int MAX_LEVEL = csfv_pkg::MAX_LEVEL_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [csfv_pkg::IW-1:0]     row_index,
    input  logic [csfv_pkg::IW-1:0]     col_index,
    input  logic [csfv_pkg::LW-1:0]     level,
    output logic                        out_valid,
    output csfv_pkg::side_t             out_side,
    output logic [csfv_pkg::TW-1:0]     s1,
    output logic [csfv_pkg::TW-1:0]     c1,
    output logic [csfv_pkg::TW-1:0]     s2,
    output logic [csfv_pkg::TW-1:0]     c2
);
    localparam int N    = 1 << MAX_LEVEL;
    localparam int HALF = N / 2;
    localparam int KW   = MAX_LEVEL + 1;
    localparam int SW   = csfv_pkg::IW + MAX_LEVEL;
    localparam int JW   = MAX_LEVEL;

    logic [csfv_pkg::TW-1:0] sin_tab [HALF+1];
    logic [csfv_pkg::TW-1:0] cos_tab [HALF+1];

    for (genvar j = 0; j <= HALF; j++) begin : g_tab
        assign sin_tab[j] = csfv_pkg::TW'(csfv_pkg::grid_sin(2 * j, MAX_LEVEL));
        assign cos_tab[j] = csfv_pkg::TW'(csfv_pkg::grid_cos(2 * j, MAX_LEVEL));
    end

    logic [csfv_pkg::LW-1:0] lv;
    logic [csfv_pkg::LW-1:0] shamt;
    logic [SW-1:0]           side_len;
    logic [SW-1:0]           row_sh;
    logic [SW-1:0]           col_sh;
    logic                    err;
    logic [KW-1:0]           k1;
    logic [KW-1:0]           k2;
    logic                    lo1;
    logic                    lo2;
    logic [KW-1:0]           d1;
    logic [KW-1:0]           d2;
    logic [JW-1:0]           j1;
    logic [JW-1:0]           j2;

    always_comb
    begin
        lv       = (level > csfv_pkg::LW'(MAX_LEVEL)) ? csfv_pkg::LW'(MAX_LEVEL) : level;
        shamt    = csfv_pkg::LW'(MAX_LEVEL) - lv;
        side_len = SW'(1) << lv;
        err      = (SW'(row_index) > side_len) || (SW'(col_index) > side_len);
        col_sh   = SW'(col_index) << shamt;
        row_sh   = SW'(row_index) << shamt;
        // out-of-range items look up the center entry; their result is zeroed later
        k1       = err ? KW'(HALF) : col_sh[KW-1:0];
        k2       = err ? KW'(HALF) : KW'(N) - row_sh[KW-1:0];
        lo1      = k1 < KW'(HALF);
        lo2      = k2 < KW'(HALF);
        d1       = lo1 ? KW'(HALF) - k1 : k1 - KW'(HALF);
        d2       = lo2 ? KW'(HALF) - k2 : k2 - KW'(HALF);
        j1       = d1[JW-1:0];
        j2       = d2[JW-1:0];
    end

    logic valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_side.err   <= err;
            out_side.neg_y <= lo2;
            out_side.neg_z <= !lo1;
            s1             <= sin_tab[j1];
            c1             <= cos_tab[j1];
            s2             <= sin_tab[j2];
            c2             <= cos_tab[j2];
        end
    end

    assign out_valid = valid_reg;
endmodule

[sv/csfv_vec.sv]
// Cross product components, their squares and the sum of squares (three stages).
module csfv_vec (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  csfv_pkg::side_t             in_side,
    input  logic [csfv_pkg::TW-1:0]     s1,
    input  logic [csfv_pkg::TW-1:0]     c1,
    input  logic [csfv_pkg::TW-1:0]     s2,
    input  logic [csfv_pkg::TW-1:0]     c2,
    output logic                        out_valid,
    output csfv_pkg::side_t             out_side,
    output logic [csfv_pkg::VW-1:0]     vx,
    output logic [csfv_pkg::VW-1:0]     vy,
    output logic [csfv_pkg::VW-1:0]     vz,
    output logic [csfv_pkg::SQW-1:0]    sumsq
);
    localparam int PW = 2 * csfv_pkg::TW;
    localparam int QSW = 2 * csfv_pkg::VW;

    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic [PW-1:0] pz;

    assign px = PW'(c1) * PW'(c2);
    assign py = PW'(c1) * PW'(s2);
    assign pz = PW'(s1) * PW'(c2);

    logic [2:0]                  valid_reg;
    csfv_pkg::side_t             side_reg [3];
    logic [csfv_pkg::VW-1:0]     vx_reg [3];
    logic [csfv_pkg::VW-1:0]     vy_reg [3];
    logic [csfv_pkg::VW-1:0]     vz_reg [3];
    logic [QSW-1:0]              qx_reg;
    logic [QSW-1:0]              qy_reg;
    logic [QSW-1:0]              qz_reg;
    logic [csfv_pkg::SQW-1:0]    sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            vx_reg[0]   <= px[csfv_pkg::FRAC+csfv_pkg::VW-1:csfv_pkg::FRAC];
            vy_reg[0]   <= py[csfv_pkg::FRAC+csfv_pkg::VW-1:csfv_pkg::FRAC];
            vz_reg[0]   <= pz[csfv_pkg::FRAC+csfv_pkg::VW-1:csfv_pkg::FRAC];

            side_reg[1] <= side_reg[0];
            vx_reg[1]   <= vx_reg[0];
            vy_reg[1]   <= vy_reg[0];
            vz_reg[1]   <= vz_reg[0];
            qx_reg      <= QSW'(vx_reg[0]) * QSW'(vx_reg[0]);
            qy_reg      <= QSW'(vy_reg[0]) * QSW'(vy_reg[0]);
            qz_reg      <= QSW'(vz_reg[0]) * QSW'(vz_reg[0]);

            side_reg[2] <= side_reg[1];
            vx_reg[2]   <= vx_reg[1];
            vy_reg[2]   <= vy_reg[1];
            vz_reg[2]   <= vz_reg[1];
            sum_reg     <= csfv_pkg::SQW'(qx_reg) + csfv_pkg::SQW'(qy_reg)
                         + csfv_pkg::SQW'(qz_reg);
        end
    end

    assign out_valid = valid_reg[2];
    assign out_side  = side_reg[2];
    assign vx        = vx_reg[2];
    assign vy        = vy_reg[2];
    assign vz        = vz_reg[2];
    assign sumsq     = sum_reg;
endmodule

[sv/csfv_isqrt.sv]
// Pipelined integer square root: one result bit per stage, payload carried alongside.
module csfv_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  csfv_pkg::side_t             in_side,
    input  logic [csfv_pkg::VW-1:0]     in_vx,
    input  logic [csfv_pkg::VW-1:0]     in_vy,
    input  logic [csfv_pkg::VW-1:0]     in_vz,
    input  logic [csfv_pkg::SQW-1:0]    sumsq,
    output logic                        out_valid,
    output csfv_pkg::side_t             out_side,
    output logic [csfv_pkg::VW-1:0]     out_vx,
    output logic [csfv_pkg::VW-1:0]     out_vy,
    output logic [csfv_pkg::VW-1:0]     out_vz,
    output logic [csfv_pkg::NW-1:0]     norm
);
    localparam int DW    = csfv_pkg::SQW;
    localparam int STEPS = DW / 2;

    logic [STEPS-1:0]            valid_reg;
    csfv_pkg::side_t             side_reg [STEPS];
    logic [csfv_pkg::VW-1:0]     vx_reg [STEPS];
    logic [csfv_pkg::VW-1:0]     vy_reg [STEPS];
    logic [csfv_pkg::VW-1:0]     vz_reg [STEPS];
    logic [DW-1:0]               rem_reg [STEPS];
    logic [DW-1:0]               res_reg [STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic [DW-1:0] BIT = DW'(1) << (DW - 2 - 2 * i);

        logic [DW-1:0]           rem_in;
        logic [DW-1:0]           res_in;
        csfv_pkg::side_t         side_in;
        logic [csfv_pkg::VW-1:0] vx_in;
        logic [csfv_pkg::VW-1:0] vy_in;
        logic [csfv_pkg::VW-1:0] vz_in;
        logic [DW-1:0]           trial;
        logic [DW-1:0]           rem_next;
        logic [DW-1:0]           res_next;

        if (i == 0) begin : g_first
            assign rem_in  = sumsq;
            assign res_in  = '0;
            assign side_in = in_side;
            assign vx_in   = in_vx;
            assign vy_in   = in_vy;
            assign vz_in   = in_vz;
        end else begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign res_in  = res_reg[i-1];
            assign side_in = side_reg[i-1];
            assign vx_in   = vx_reg[i-1];
            assign vy_in   = vy_reg[i-1];
            assign vz_in   = vz_reg[i-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                res_reg[i]  <= res_next;
                side_reg[i] <= side_in;
                vx_reg[i]   <= vx_in;
                vy_reg[i]   <= vy_in;
                vz_reg[i]   <= vz_in;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];
    assign out_vx    = vx_reg[STEPS-1];
    assign out_vy    = vy_reg[STEPS-1];
    assign out_vz    = vz_reg[STEPS-1];
    assign norm      = res_reg[STEPS-1][csfv_pkg::NW-1:0];
endmodule

[sv/csfv_scale.sv]
// Radius scaling: dividend stage, restoring divide one bit a stage, sign and saturation.
module csfv_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  csfv_pkg::side_t                   in_side,
    input  logic [csfv_pkg::VW-1:0]           vx,
    input  logic [csfv_pkg::VW-1:0]           vy,
    input  logic [csfv_pkg::VW-1:0]           vz,
    input  logic [csfv_pkg::NW-1:0]           norm,
    input  logic [csfv_pkg::RW-1:0]           radius,
    output logic                              out_valid,
    output logic signed [csfv_pkg::OW-1:0]    vert_x,
    output logic signed [csfv_pkg::OW-1:0]    vert_y,
    output logic signed [csfv_pkg::OW-1:0]    vert_z,
    output logic                              index_error
);
    localparam int DVW   = csfv_pkg::DVW;
    localparam int QW    = csfv_pkg::QW;
    localparam int OW    = csfv_pkg::OW;
    localparam int DEPTH = QW + 2;   // dividend, QW divide steps, output

    logic [DEPTH-1:0]            valid_reg;
    csfv_pkg::side_t             side_reg [QW+1];
    logic [csfv_pkg::NW-1:0]     norm_reg [QW+1];
    logic [DVW-1:0]              rem_reg  [QW+1][3];
    logic [QW-1:0]               quo_reg  [QW+1][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    logic [csfv_pkg::VW-1:0] mag [3];
    assign mag[0] = vx;
    assign mag[1] = vy;
    assign mag[2] = vz;

    // dividend = mag * radius + norm / 2 gives round-half-up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            norm_reg[0] <= norm;
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l] <= DVW'(mag[l]) * DVW'(radius) + DVW'(norm >> 1);
                quo_reg[0][l] <= '0;
            end
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int B = QW - 1 - i;

        logic [DVW-1:0] dsh;
        assign dsh = DVW'(norm_reg[i]) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                norm_reg[i+1] <= norm_reg[i];
                for (int l = 0; l < 3; l++)
                begin
                    if (rem_reg[i][l] >= dsh)
                    begin
                        rem_reg[i+1][l]    <= rem_reg[i][l] - dsh;
                        quo_reg[i+1][l]    <= quo_reg[i][l] | (QW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[i+1][l]    <= rem_reg[i][l];
                        quo_reg[i+1][l]    <= quo_reg[i][l];
                    end
                end
            end
        end
    end

    logic [OW-1:0] res_next [3];
    logic          neg [3];
    logic          zero_out;

    always_comb
    begin
        neg[0]   = 1'b0;
        neg[1]   = side_reg[QW].neg_y;
        neg[2]   = side_reg[QW].neg_z;
        zero_out = side_reg[QW].err || (norm_reg[QW] == '0);
        for (int l = 0; l < 3; l++)
        begin
            if (zero_out)
                res_next[l] = '0;
            else if (neg[l])
                res_next[l] = (quo_reg[QW][l] > QW'(32768)) ? OW'(32768)
                                                           : OW'(-quo_reg[QW][l]);
            else
                res_next[l] = (quo_reg[QW][l] > QW'(32767)) ? OW'(32767)
                                                           : OW'(quo_reg[QW][l]);
        end
    end

    logic [OW-1:0] x_reg;
    logic [OW-1:0] y_reg;
    logic [OW-1:0] z_reg;
    logic          err_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= res_next[0];
            y_reg   <= res_next[1];
            z_reg   <= res_next[2];
            err_reg <= side_reg[QW].err;
        end
    end

    assign out_valid   = valid_reg[DEPTH-1];
    assign vert_x      = signed'(x_reg);
    assign vert_y      = signed'(y_reg);
    assign vert_z      = signed'(z_reg);
    assign index_error = err_reg;
endmodule

[sv/csfv_checker.sv]
// Port-level checker for the vertex generator, bound to the top level.
`include "cube_sphere_face_vertex_gen_macros.svh"

module csfv_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              grid_ready,
    input logic                              vertex_valid,
    input logic                              vertex_ready,
    input logic signed [csfv_pkg::OW-1:0]    vert_x,
    input logic signed [csfv_pkg::OW-1:0]    vert_y,
    input logic signed [csfv_pkg::OW-1:0]    vert_z,
    input logic                              index_error
);
    `CSFV_ASSERT(a_hold, vertex_valid && !vertex_ready |=> vertex_valid, "vertex item dropped")
    `CSFV_ASSERT(a_err_zero, vertex_valid && index_error |-> vert_x == 0 && vert_y == 0 && vert_z == 0, "error item not zero")
    `CSFV_ASSERT(a_x_pos, vertex_valid |-> !vert_x[csfv_pkg::OW-1], "negative x on +X face")
    `CSFV_ASSERT(a_flow, grid_ready == (!vertex_valid || vertex_ready), "input ready not tied to output flow")
    `CSFV_ASSERT_ALWAYS(a_rst, !rst_n |-> !vertex_valid, "vertex valid during reset")
endmodule

bind cube_sphere_face_vertex_gen csfv_checker u_csfv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .grid_ready   (grid.ready),
    .vertex_valid (vertex.valid),
    .vertex_ready (vertex.ready),
    .vert_x       (vertex.vert_x),
    .vert_y       (vertex.vert_y),
    .vert_z       (vertex.vert_z),
    .index_error  (vertex.index_error)
);
